// ----- design/ysc_pkg.sv -----
// Shared types and constants for the YMODEM sender control block.
package ysc_pkg;

  localparam int unsigned FifoDepth = 2;
  localparam logic [7:0] ErrorLimitReset = 8'd10;
  localparam logic [7:0] BlockReset = 8'hFF;

  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCan = 8'h18;
  localparam logic [7:0] ChC   = 8'h43;

  localparam logic OpByte  = 1'b0;
  localparam logic OpBegin = 1'b1;

  typedef enum logic [2:0] {
    ClsNak   = 3'd0,
    ClsC     = 3'd1,
    ClsAck   = 3'd2,
    ClsCan   = 3'd3,
    ClsOther = 3'd4
  } cls_e;

  typedef enum logic [2:0] {
    ActNone   = 3'd0,
    ActNew    = 3'd1,
    ActResend = 3'd2,
    ActEot    = 3'd3,
    ActCan    = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    StBusy   = 3'd0,
    StDone1  = 3'd1,
    StDone   = 3'd2,
    StExcess = 3'd3,
    StRcvCan = 3'd4,
    StProto  = 3'd5
  } st_e;

  // Classified command between front and back.
  typedef struct packed {
    logic opcode;
    cls_e cls;
    logic more;
  } cmd_t;

  function automatic cls_e classify(input logic [7:0] b);
    cls_e c;
    c = ClsOther;
    if (b == ChNak) c = ClsNak;
    else if (b == ChC) c = ClsC;
    else if (b == ChAck) c = ClsAck;
    else if (b == ChCan) c = ClsCan;
    return c;
  endfunction

endpackage

// ----- design/ysc_front.sv -----
// Front part: accepts input words and classifies the received byte.
module ysc_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,  // rx_byte [7:0], more_data [8], zero pad
  input  logic              s_axis_tuser,  // opcode [0]
  input  logic              full_i,
  output logic              push_o,
  output ysc_pkg::cmd_t     cmd_o
);

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  always_comb begin
    cmd_o.opcode = s_axis_tuser;
    cmd_o.cls    = ysc_pkg::classify(s_axis_tdata[7:0]);
    cmd_o.more   = s_axis_tdata[8];
  end

endmodule

// ----- design/ysc_fifo.sv -----
// Short register queue between the front and the back part.
module ysc_fifo #(
  parameter int unsigned Depth = ysc_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ysc_pkg::cmd_t     wdata_i,
  input  logic              pop_i,
  output ysc_pkg::cmd_t     rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ysc_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    if (pop_i)  rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

// ----- design/ysc_back.sv -----
// Back part: phase machine, retry and block counters, output register.
module ysc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              empty_i,
  input  ysc_pkg::cmd_t     cmd_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata   // action [2:0], block_number [10:3],
                                           // status [13:11], zero pad
);

  typedef enum logic [7:0] {
    PhHdr    = 8'b00000001,
    PhHdrAck = 8'b00000010,
    PhFirst  = 8'b00000100,
    PhXmit   = 8'b00001000,
    PhCancel = 8'b00010000,
    PhEot1   = 8'b00100000,
    PhEot2   = 8'b01000000,
    PhEnd    = 8'b10000000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [7:0]       retry_q, retry_d;
  logic [7:0]       block_q, block_d;
  logic [7:0]       limit_q;
  logic             ovalid_q;
  ysc_pkg::act_e    act;
  ysc_pkg::st_e     st;
  logic [7:0]       num;
  logic             req;
  logic [15:0]      odata_q;

  assign pop_o = !empty_i && (!ovalid_q || m_axis_tready);
  assign req   = (cmd_i.cls == ysc_pkg::ClsNak) || (cmd_i.cls == ysc_pkg::ClsC);

  always_comb begin
    phase_d = phase_q;
    retry_d = retry_q;
    block_d = block_q;
    act     = ysc_pkg::ActNone;
    st      = ysc_pkg::StBusy;
    num     = 8'd0;
    if (cmd_i.opcode == ysc_pkg::OpBegin) begin
      phase_d = PhHdr;
      retry_d = 8'd0;
      block_d = ysc_pkg::BlockReset;
    end else begin
      unique case (phase_q)
        PhHdr: begin
          if (req) begin
            block_d = block_q + 8'd1;
            act     = ysc_pkg::ActNew;
            num     = block_d;
            phase_d = PhHdrAck;
          end
        end
        PhHdrAck: begin
          if (cmd_i.cls == ysc_pkg::ClsAck) phase_d = PhFirst;
        end
        PhFirst: begin
          if (req) begin
            if (cmd_i.more) begin
              block_d = block_q + 8'd1;
              act     = ysc_pkg::ActNew;
              num     = block_d;
              phase_d = PhXmit;
            end else begin
              act     = ysc_pkg::ActEot;
              phase_d = PhEot1;
            end
          end else begin
            st      = ysc_pkg::StProto;
            phase_d = PhEnd;
          end
        end
        PhXmit: begin
          if (cmd_i.cls == ysc_pkg::ClsAck) begin
            retry_d = 8'd0;
            if (cmd_i.more) begin
              block_d = block_q + 8'd1;
              act     = ysc_pkg::ActNew;
              num     = block_d;
            end else begin
              act     = ysc_pkg::ActEot;
              phase_d = PhEot1;
            end
          end else if (req) begin
            if (retry_q < limit_q) begin
              act     = ysc_pkg::ActResend;
              num     = block_q;
              retry_d = retry_q + 8'd1;
            end else begin
              act     = ysc_pkg::ActCan;
              st      = ysc_pkg::StExcess;
              phase_d = PhEnd;
            end
          end else if (cmd_i.cls == ysc_pkg::ClsCan) begin
            phase_d = PhCancel;
          end else begin
            st      = ysc_pkg::StProto;
            phase_d = PhEnd;
          end
        end
        PhCancel: begin
          st      = (cmd_i.cls == ysc_pkg::ClsCan) ? ysc_pkg::StRcvCan : ysc_pkg::StProto;
          phase_d = PhEnd;
        end
        PhEot1: begin
          if (cmd_i.cls == ysc_pkg::ClsNak) begin
            act     = ysc_pkg::ActEot;
            phase_d = PhEot2;
          end else begin
            st      = (cmd_i.cls == ysc_pkg::ClsAck) ? ysc_pkg::StDone1 : ysc_pkg::StProto;
            phase_d = PhEnd;
          end
        end
        PhEot2: begin
          st      = (cmd_i.cls == ysc_pkg::ClsAck) ? ysc_pkg::StDone : ysc_pkg::StProto;
          phase_d = PhEnd;
        end
        PhEnd: begin
          phase_d = PhEnd;
        end
        default: begin
          phase_d = PhEnd;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhEnd;
      retry_q  <= 8'd0;
      block_q  <= ysc_pkg::BlockReset;
      limit_q  <= ysc_pkg::ErrorLimitReset;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (pop_o) begin
        phase_q  <= phase_d;
        retry_q  <= retry_d;
        block_q  <= block_d;
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Hold the word until taken; load a new one on every pop.
  always_ff @(posedge clk_i) begin
    if (pop_o) odata_q <= {2'b00, st, num, act};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

// ----- design/ymodem_sender_control_unit.sv -----
// Top level of the YMODEM sender control block.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: rx_byte, more_data; tuser: opcode
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: action, block_number, status
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i: error_limit
//
// One word in and one result word out per cycle while m_axis_tready stays high;
// the phase machine in the back part decides each word as it leaves the queue,
// and the result word is registered. While a result waits in the output
// register the queue takes up to FifoDepth more words, then s_axis_tready drops.
// Reset clears the queue, sets the phase to idle, the block number to 255 and
// error_limit to 10.
module ymodem_sender_control_unit #(
  parameter int unsigned FifoDepth = ysc_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,      // error_limit [7:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // rx_byte [7:0], more_data [8], zero pad
  input  logic        s_axis_tuser,    // opcode [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata     // action [2:0], block_number [10:3],
                                       // status [13:11], zero pad
);

  ysc_pkg::cmd_t wcmd, rcmd;
  logic          fifo_push;
  logic          fifo_full;
  logic          fifo_pop;
  logic          fifo_empty;

  assign cfg_ready_o = 1'b1;

  ysc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (fifo_full),
    .push_o        (fifo_push),
    .cmd_o         (wcmd)
  );

  ysc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (wcmd),
    .pop_i   (fifo_pop),
    .rdata_o (rcmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  ysc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .empty_i       (fifo_empty),
    .cmd_i         (rcmd),
    .pop_o         (fifo_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- bench/tb_ymodem_sender_control_unit.sv -----
// Self-checking testbench for the YMODEM sender control block.
`timescale 1ns / 1ps

module tb_ymodem_sender_control_unit;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 6;
  localparam int SegWords = 180;

  typedef enum logic [2:0] {
    PhHeader, PhHeaderAck, PhFirst, PhXmit, PhCancel, PhEot1, PhEot2, PhIdle
  } xfer_phase_e;

  typedef struct packed {
    ysc_pkg::act_e action;
    logic [7:0]    blk_no;
    ysc_pkg::st_e  status;
  } reply_t;

  // One stimulus word; pin marks a row whose expected reply is typed in.
  typedef struct packed {
    logic       op;
    logic [7:0] rx;
    logic       more;
    logic       pin;
    reply_t     want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // rx_byte [7:0], more_data [8], zero pad
  logic        s_axis_tuser;   // opcode [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // action [2:0], block_number [10:3], status [13:11]

  // Transfer model state
  xfer_phase_e xfer_phase;
  logic [7:0]  retries;
  logic [7:0]  cur_blk;
  logic [7:0]  retry_limit;

  reply_t reply_q[$];
  row_t   sent_q[$];

  int mismatches;
  int words_in;
  int cycles;
  int src_idle;
  int sink_idle;
  int noise_pct;

  ymodem_sender_control_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("ymodem_sender_control_unit verification failed");
      $finish;
    end
  end

  // Advance the transfer model by one word and return the reply it produces.
  function automatic reply_t step_transfer(input logic op, input logic [7:0] rx,
                                           input logic more);
    reply_t r;
    logic   ask;
    r.action = ysc_pkg::ActNone;
    r.blk_no = 8'd0;
    r.status = ysc_pkg::StBusy;
    ask = (rx == ysc_pkg::ChNak) || (rx == ysc_pkg::ChC);
    if (op == ysc_pkg::OpBegin) begin
      xfer_phase = PhHeader;
      retries = 8'd0;
      cur_blk = ysc_pkg::BlockReset;
    end else begin
      case (xfer_phase)
        PhHeader: begin
          if (ask) begin
            cur_blk = cur_blk + 8'd1;
            r.action = ysc_pkg::ActNew;
            r.blk_no = cur_blk;
            xfer_phase = PhHeaderAck;
          end
        end
        PhHeaderAck: begin
          if (rx == ysc_pkg::ChAck) xfer_phase = PhFirst;
        end
        PhFirst: begin
          if (ask && more) begin
            cur_blk = cur_blk + 8'd1;
            r.action = ysc_pkg::ActNew;
            r.blk_no = cur_blk;
            xfer_phase = PhXmit;
          end else if (ask) begin
            r.action = ysc_pkg::ActEot;
            xfer_phase = PhEot1;
          end else begin
            r.status = ysc_pkg::StProto;
            xfer_phase = PhIdle;
          end
        end
        PhXmit: begin
          if (rx == ysc_pkg::ChAck) begin
            retries = 8'd0;
            if (more) begin
              cur_blk = cur_blk + 8'd1;
              r.action = ysc_pkg::ActNew;
              r.blk_no = cur_blk;
            end else begin
              r.action = ysc_pkg::ActEot;
              xfer_phase = PhEot1;
            end
          end else if (ask) begin
            if (retries < retry_limit) begin
              r.action = ysc_pkg::ActResend;
              r.blk_no = cur_blk;
              retries = retries + 8'd1;
            end else begin
              r.action = ysc_pkg::ActCan;
              r.status = ysc_pkg::StExcess;
              xfer_phase = PhIdle;
            end
          end else if (rx == ysc_pkg::ChCan) begin
            xfer_phase = PhCancel;
          end else begin
            r.status = ysc_pkg::StProto;
            xfer_phase = PhIdle;
          end
        end
        PhCancel: begin
          r.status = (rx == ysc_pkg::ChCan) ? ysc_pkg::StRcvCan : ysc_pkg::StProto;
          xfer_phase = PhIdle;
        end
        PhEot1: begin
          if (rx == ysc_pkg::ChNak) begin
            r.action = ysc_pkg::ActEot;
            xfer_phase = PhEot2;
          end else begin
            r.status = (rx == ysc_pkg::ChAck) ? ysc_pkg::StDone1 : ysc_pkg::StProto;
            xfer_phase = PhIdle;
          end
        end
        PhEot2: begin
          r.status = (rx == ysc_pkg::ChAck) ? ysc_pkg::StDone : ysc_pkg::StProto;
          xfer_phase = PhIdle;
        end
        default: xfer_phase = PhIdle;
      endcase
    end
    return r;
  endfunction

  // Track accepted words, register writes and result words at the rising edge.
  always @(posedge clk_i) begin : watch
    reply_t pred;
    reply_t want;
    row_t   w;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) retry_limit = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        words_in++;
        pred = step_transfer(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
        w = sent_q.pop_front();
        reply_q.push_back(w.pin ? w.want : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (m_axis_tdata[2:0] !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, m_axis_tdata[2:0]);
            mismatches++;
          end
          if (m_axis_tdata[10:3] !== want.blk_no) begin
            $error("block_number: expected %0d, got %0d", want.blk_no, m_axis_tdata[10:3]);
            mismatches++;
          end
          if (m_axis_tdata[13:11] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tdata[13:11]);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver side: stall at random.
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  function automatic row_t word_row(input logic op, input logic [7:0] rx, input logic more,
                                    input logic pin, input ysc_pkg::act_e a,
                                    input logic [7:0] n, input ysc_pkg::st_e s);
    row_t w;
    w.op = op;
    w.rx = rx;
    w.more = more;
    w.pin = pin;
    w.want.action = a;
    w.want.blk_no = n;
    w.want.status = s;
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input row_t w);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    sent_q.push_back(w);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, w.more, w.rx};
    s_axis_tuser <= w.op;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] rx, input logic more);
    send_word(word_row(ysc_pkg::OpByte, rx, more, 1'b0, ysc_pkg::ActNone, 8'd0,
                       ysc_pkg::StBusy));
  endtask

  // Replace a byte by a random one now and then.
  function automatic logic [7:0] garble(input logic [7:0] b);
    return ($urandom_range(99) < noise_pct) ? 8'($urandom_range(255)) : b;
  endfunction

  function automatic logic [7:0] pick_request();
    return $urandom_range(1) ? ysc_pkg::ChC : ysc_pkg::ChNak;
  endfunction

  // One file transfer with random retries, noise and receiver cancels.
  task automatic run_transfer(input int blocks, input int retry_max);
    send_word(word_row(ysc_pkg::OpBegin, 8'($urandom_range(255)), 1'($urandom_range(1)),
                       1'b0, ysc_pkg::ActNone, 8'd0, ysc_pkg::StBusy));
    if ($urandom_range(4) == 0) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    send_byte(garble(pick_request()), 1'($urandom_range(1)));
    if ($urandom_range(4) == 0) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    send_byte(garble(ysc_pkg::ChAck), 1'($urandom_range(1)));
    send_byte(garble(pick_request()), blocks > 0);
    for (int i = 1; i <= blocks; i++) begin
      repeat ($urandom_range(retry_max)) send_byte(garble(pick_request()), 1'($urandom_range(1)));
      if ($urandom_range(99) < noise_pct) begin
        send_byte(ysc_pkg::ChCan, 1'($urandom_range(1)));
        send_byte(garble(ysc_pkg::ChCan), 1'($urandom_range(1)));
        return;
      end
      send_byte(garble(ysc_pkg::ChAck), i < blocks);
    end
    if ($urandom_range(1)) send_byte(garble(ysc_pkg::ChNak), 1'($urandom_range(1)));
    send_byte(garble(ysc_pkg::ChAck), 1'($urandom_range(1)));
  endtask

  // Hold the sender until every expected result word has come back.
  task automatic drain();
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    row_t       script [27];
    logic [7:0] seg_limit [6];
    int         target;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 16'd0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    words_in = 0;
    cycles = 0;
    src_idle = 12;
    sink_idle = 51;
    noise_pct = 5;
    xfer_phase = PhIdle;
    retries = 8'd0;
    cur_blk = ysc_pkg::BlockReset;
    retry_limit = ysc_pkg::ErrorLimitReset;

    script[0]  = word_row(ysc_pkg::OpByte,  8'hFF, 1'b0, 1'b1, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[1]  = word_row(ysc_pkg::OpBegin, 8'hFF, 1'b1, 1'b1, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[2]  = word_row(ysc_pkg::OpByte,  8'h00, 1'b0, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[3]  = word_row(ysc_pkg::OpByte,  ysc_pkg::ChC,   1'b1, 1'b1, ysc_pkg::ActNew, 8'd0,
                          ysc_pkg::StBusy);
    script[4]  = word_row(ysc_pkg::OpByte,  ysc_pkg::ChNak, 1'b0, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[5]  = word_row(ysc_pkg::OpByte,  ysc_pkg::ChAck, 1'b0, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[6]  = word_row(ysc_pkg::OpByte,  ysc_pkg::ChNak, 1'b1, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[7]  = word_row(ysc_pkg::OpByte,  ysc_pkg::ChC,   1'b0, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[8]  = word_row(ysc_pkg::OpByte,  ysc_pkg::ChAck, 1'b1, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[9]  = word_row(ysc_pkg::OpByte,  ysc_pkg::ChCan, 1'b0, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[10] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChCan, 1'b0, 1'b1, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StRcvCan);
    script[11] = word_row(ysc_pkg::OpBegin, 8'h00, 1'b0, 1'b1, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[12] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChC,   1'b0, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[13] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChAck, 1'b1, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[14] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChC,   1'b0, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[15] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChNak, 1'b1, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[16] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChAck, 1'b0, 1'b1, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StDone);
    script[17] = word_row(ysc_pkg::OpBegin, 8'h80, 1'b0, 1'b1, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[18] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChNak, 1'b1, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[19] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChAck, 1'b0, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[20] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChNak, 1'b1, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[21] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChAck, 1'b0, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[22] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChAck, 1'b1, 1'b1, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StDone1);
    script[23] = word_row(ysc_pkg::OpBegin, 8'h55, 1'b1, 1'b1, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[24] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChC,   1'b0, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[25] = word_row(ysc_pkg::OpByte,  ysc_pkg::ChAck, 1'b0, 1'b0, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StBusy);
    script[26] = word_row(ysc_pkg::OpByte,  8'hFF, 1'b1, 1'b1, ysc_pkg::ActNone, 8'd0,
                          ysc_pkg::StProto);

    seg_limit[0] = 8'd255;
    seg_limit[1] = 8'd0;
    seg_limit[2] = 8'd2;
    seg_limit[3] = 8'd1;
    seg_limit[4] = 8'd3;
    // Nonzero so the long transfer below is never cut short by the limit.
    seg_limit[5] = 8'($urandom_range(255, 1));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) send_word(script[i]);
    s_axis_tvalid <= 1'b0;

    for (int seg = 0; seg < 6; seg++) begin
      drain();
      write_limit(seg_limit[seg]);
      src_idle = (seg < 2) ? 12 : (seg < 4) ? 51 : 0;
      sink_idle = (seg < 2) ? 51 : (seg < 4) ? 12 : 0;
      // Walk the block number through a full wrap once, without noise.
      if (seg == 5) begin
        noise_pct = 0;
        run_transfer(300, 1);
        noise_pct = 5;
      end
      target = words_in + SegWords;
      while (words_in < target) run_transfer($urandom_range(10), 3);
      s_axis_tvalid <= 1'b0;
    end

    drain();
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("ymodem_sender_control_unit verification clean");
    end else begin
      $display("ymodem_sender_control_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ysc_pkg.sv
design/ysc_front.sv
design/ysc_fifo.sv
design/ysc_back.sv
design/ymodem_sender_control_unit.sv
bench/tb_ymodem_sender_control_unit.sv
